### sv/tsgs_pkg.sv
package tsgs_pkg;

  localparam logic [3:0] PHASE_A = 4'b1010;
  localparam logic [3:0] PHASE_B = 4'b1001;
  localparam logic [3:0] PHASE_C = 4'b0101;
  localparam logic [3:0] PHASE_D = 4'b0110;

  localparam logic [3:0] BYTE_MAX = 4'd13;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef enum logic [1:0] {
    SLOT_ONE   = 2'd0,
    SLOT_TWO   = 2'd1,
    SLOT_THREE = 2'd2
  } slot_t;

  // per-motor control for one accepted request
  typedef struct packed {
    logic goal_we;
    logic step_en;
    logic clear;
  } motor_ctrl_t;

  function automatic logic [3:0] next_phase(input logic [3:0] p);
    logic [3:0] n;
    case (p)
      PHASE_A: n = PHASE_B;
      PHASE_B: n = PHASE_C;
      PHASE_C: n = PHASE_D;
      default: n = PHASE_A;
    endcase
    return n;
  endfunction

  // 23*b + b/2 for a clamped byte, at most 305
  function automatic logic [8:0] goal_cut(input logic [3:0] b);
    logic [8:0] c;
    c = 9'(b) * 9'd23 + 9'(b[3:1]);
    return c;
  endfunction

endpackage

### sv/tsgs_motor.sv
module tsgs_motor #(
  parameter int COUNT_WIDTH = 10,
  parameter int RESET_GOAL  = 332
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tsgs_pkg::motor_ctrl_t    ctrl,
  input  logic [COUNT_WIDTH-1:0]   goal_wdata,
  output logic                     busy,
  output logic [3:0]               coil
);
  import tsgs_pkg::*;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] goal_r, goal_nxt;
  logic [3:0]             phase_r, phase_nxt;
  logic [3:0]             coil_r, coil_nxt;

  assign busy = count_r < goal_r;
  assign coil = coil_r;

  always_comb begin
    count_nxt = count_r;
    goal_nxt  = goal_r;
    phase_nxt = phase_r;
    coil_nxt  = coil_r;
    if (ctrl.goal_we) begin
      goal_nxt = goal_wdata;
    end
    if (ctrl.step_en && busy) begin
      phase_nxt = next_phase(phase_r);
      coil_nxt  = phase_nxt;
      count_nxt = count_r + COUNT_WIDTH'(1);
    end
    // phase and goal survive the finish
    if (ctrl.clear) begin
      count_nxt = '0;
      coil_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      goal_r  <= COUNT_WIDTH'(RESET_GOAL);
      phase_r <= PHASE_A;
      coil_r  <= '0;
    end else begin
      count_r <= count_nxt;
      goal_r  <= goal_nxt;
      phase_r <= phase_nxt;
      coil_r  <= coil_nxt;
    end
  end

endmodule

### sv/three_stepper_goal_sequencer.sv
// Three-motor full-step sequencer. Each request is a timer tick (kind 0) or a
// goal byte (kind 1); every request gives exactly one result in the cycle after
// it is taken, and a new request can be taken every cycle unless the result
// side stalls. Three bytes in a row set the goals of motors one, two and
// three (bytes above 13 count as 13) and the third arms the block. While
// armed, a tick advances each unfinished motor by one coil phase; the first
// tick that finds all motors finished disarms, clears counts and coils, and
// raises done_pulse. The result fields are the state registers themselves,
// so a stalled result holds because the input side stalls with it: the
// block takes a request whenever its result register is empty or being taken.
module three_stepper_goal_sequencer #(
  parameter int STEPS_PER_REV = 332,
  parameter int COUNT_WIDTH   = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [3:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_coil_one,
  output logic [3:0] out_coil_two,
  output logic [3:0] out_coil_three,
  output logic       out_done_pulse,
  output logic       out_armed
);
  import tsgs_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] BASE_ONE   = COUNT_WIDTH'(STEPS_PER_REV);
  localparam logic [COUNT_WIDTH-1:0] BASE_TWO   = COUNT_WIDTH'(2 * STEPS_PER_REV + 4);
  localparam logic [COUNT_WIDTH-1:0] BASE_THREE = COUNT_WIDTH'(3 * STEPS_PER_REV - 2);

  logic        out_valid_r, out_valid_nxt;
  logic        done_r, done_nxt;
  logic        running_r, running_nxt;
  slot_t       slot_r, slot_nxt;
  logic        accept;
  logic        is_byte, is_tick;
  logic [3:0]  byte_clamped;
  logic [COUNT_WIDTH-1:0] cut;
  logic [COUNT_WIDTH-1:0] goal_one, goal_two, goal_three;
  logic        busy_one, busy_two, busy_three;
  logic        finish;
  motor_ctrl_t ctrl_one, ctrl_two, ctrl_three;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_byte  = accept && (in_kind == KIND_BYTE);
  assign is_tick  = accept && (in_kind == KIND_TICK) && running_r;
  assign finish   = is_tick && !(busy_one || busy_two || busy_three);

  assign byte_clamped = (in_byte_value > BYTE_MAX) ? BYTE_MAX : in_byte_value;
  assign cut          = COUNT_WIDTH'(goal_cut(byte_clamped));
  assign goal_one     = BASE_ONE - cut;
  assign goal_two     = BASE_TWO - cut;
  assign goal_three   = BASE_THREE - cut;

  // next state
  always_comb begin
    slot_nxt    = slot_r;
    running_nxt = running_r;
    if (is_byte) begin
      case (slot_r)
        SLOT_TWO:   slot_nxt = SLOT_THREE;
        SLOT_THREE: begin
          slot_nxt    = SLOT_ONE;
          running_nxt = 1'b1;
        end
        default:    slot_nxt = SLOT_TWO;
      endcase
    end
    if (finish) begin
      running_nxt = 1'b0;
    end
  end

  // motor controls
  always_comb begin
    ctrl_one   = '0;
    ctrl_two   = '0;
    ctrl_three = '0;
    if (is_byte) begin
      case (slot_r)
        SLOT_TWO:   ctrl_two.goal_we   = 1'b1;
        SLOT_THREE: ctrl_three.goal_we = 1'b1;
        default:    ctrl_one.goal_we   = 1'b1;
      endcase
    end
    ctrl_one.step_en   = is_tick;
    ctrl_two.step_en   = is_tick;
    ctrl_three.step_en = is_tick;
    ctrl_one.clear     = finish;
    ctrl_two.clear     = finish;
    ctrl_three.clear   = finish;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    done_nxt      = done_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      done_nxt      = finish;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      running_r   <= 1'b0;
      slot_r      <= SLOT_ONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
      running_r   <= running_nxt;
      slot_r      <= slot_nxt;
    end
  end

  tsgs_motor #(.COUNT_WIDTH(COUNT_WIDTH), .RESET_GOAL(STEPS_PER_REV)) u_motor_one (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_one),
    .goal_wdata (goal_one),
    .busy       (busy_one),
    .coil       (out_coil_one)
  );

  tsgs_motor #(.COUNT_WIDTH(COUNT_WIDTH), .RESET_GOAL(STEPS_PER_REV)) u_motor_two (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_two),
    .goal_wdata (goal_two),
    .busy       (busy_two),
    .coil       (out_coil_two)
  );

  tsgs_motor #(.COUNT_WIDTH(COUNT_WIDTH), .RESET_GOAL(STEPS_PER_REV)) u_motor_three (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl_three),
    .goal_wdata (goal_three),
    .busy       (busy_three),
    .coil       (out_coil_three)
  );

  assign out_valid      = out_valid_r;
  assign out_done_pulse = done_r;
  assign out_armed      = running_r;

endmodule

### tb/three_stepper_goal_sequencer_checker.sv
module three_stepper_goal_sequencer_checker #(
  parameter int STEPS_PER_REV = 332,
  parameter int COUNT_WIDTH   = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_kind,
  input  logic [3:0] in_byte_value,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] out_coil_one,
  input  logic [3:0] out_coil_two,
  input  logic [3:0] out_coil_three,
  input  logic       out_done_pulse,
  input  logic       out_armed,
  output int         n_fail,
  output int         n_pending,
  output int         n_done
);
  import tsgs_pkg::*;

  typedef struct packed {
    logic [3:0] coil_one;
    logic [3:0] coil_two;
    logic [3:0] coil_three;
    logic       done_pulse;
    logic       armed;
  } drive_word_t;

  drive_word_t            pending_words [$];
  slot_t                  goal_slot;
  logic                   arm_q;
  logic [COUNT_WIDTH-1:0] steps_taken  [3];
  logic [COUNT_WIDTH-1:0] steps_wanted [3];
  logic [3:0]             phase_q      [3];
  logic [3:0]             coil_q       [3];
  int                     fail_tally;
  int                     done_tally;
  int                     result_idx;

  function automatic logic [3:0] phase_after(input logic [3:0] p);
    logic [3:0] n;
    case (p)
      PHASE_A: n = PHASE_B;
      PHASE_B: n = PHASE_C;
      PHASE_C: n = PHASE_D;
      default: n = PHASE_A;
    endcase
    return n;
  endfunction

  task automatic step_motors(input logic kind, input logic [3:0] value,
                             output drive_word_t word);
    int   b;
    int   cut;
    int   g;
    logic busy [3];
    logic any;
    logic fin;
    fin = 1'b0;
    if (kind == KIND_BYTE) begin
      b   = (value > BYTE_MAX) ? int'(BYTE_MAX) : int'(value);
      cut = 23 * b + b / 2;
      case (goal_slot)
        SLOT_TWO: begin
          g = 2 * STEPS_PER_REV + 4 - cut;
          steps_wanted[1] = COUNT_WIDTH'(g);
          goal_slot = SLOT_THREE;
        end
        SLOT_THREE: begin
          g = 3 * STEPS_PER_REV - 2 - cut;
          steps_wanted[2] = COUNT_WIDTH'(g);
          goal_slot = SLOT_ONE;
          arm_q = 1'b1;
        end
        default: begin
          g = STEPS_PER_REV - cut;
          steps_wanted[0] = COUNT_WIDTH'(g);
          goal_slot = SLOT_TWO;
        end
      endcase
    end else if (arm_q) begin
      any = 1'b0;
      for (int m = 0; m < 3; m++) begin
        busy[m] = steps_taken[m] < steps_wanted[m];
        any     = any | busy[m];
      end
      for (int m = 0; m < 3; m++) begin
        if (busy[m]) begin
          phase_q[m]     = phase_after(phase_q[m]);
          coil_q[m]      = phase_q[m];
          steps_taken[m] = steps_taken[m] + COUNT_WIDTH'(1);
        end
      end
      // all motors at goal: disarm, keep phases and goals
      if (!any) begin
        arm_q = 1'b0;
        for (int m = 0; m < 3; m++) begin
          steps_taken[m] = '0;
          coil_q[m]      = '0;
        end
        fin = 1'b1;
      end
    end
    word = '{coil_one: coil_q[0], coil_two: coil_q[1], coil_three: coil_q[2],
             done_pulse: fin, armed: arm_q};
  endtask

  always @(posedge clk) begin : watch
    drive_word_t seen;
    drive_word_t want;
    if (!rst_n) begin
      pending_words.delete();
      goal_slot  = SLOT_ONE;
      arm_q      = 1'b0;
      fail_tally = 0;
      done_tally = 0;
      result_idx = 0;
      for (int m = 0; m < 3; m++) begin
        steps_taken[m]  = '0;
        steps_wanted[m] = COUNT_WIDTH'(STEPS_PER_REV);
        phase_q[m]      = PHASE_A;
        coil_q[m]       = '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{coil_one: out_coil_one, coil_two: out_coil_two,
                 coil_three: out_coil_three, done_pulse: out_done_pulse,
                 armed: out_armed};
        if (pending_words.size() == 0) begin
          if (fail_tally < 10)
            $display("result %0d arrived with no request outstanding", result_idx);
          fail_tally++;
        end else begin
          want = pending_words.pop_front();
          if (seen !== want) begin
            if (fail_tally < 10)
              $display({"result %0d: expected coils %h %h %h done %b armed %b,",
                        " got coils %h %h %h done %b armed %b"},
                       result_idx, want.coil_one, want.coil_two, want.coil_three,
                       want.done_pulse, want.armed, seen.coil_one, seen.coil_two,
                       seen.coil_three, seen.done_pulse, seen.armed);
            fail_tally++;
          end
          if (want.done_pulse) done_tally++;
        end
        result_idx++;
      end
      // the result of a request taken here comes in the following cycle at the earliest
      if (in_valid && !in_stall) begin
        step_motors(in_kind, in_byte_value, want);
        pending_words.push_back(want);
      end
    end
    n_fail    <= fail_tally;
    n_done    <= done_tally;
    n_pending <= pending_words.size();
  end

endmodule

### tb/three_stepper_goal_sequencer_tb.sv
module three_stepper_goal_sequencer_tb;
  import tsgs_pkg::*;

  localparam int RANDOM_ITEMS = 1525;
  localparam int RANDOM_CAP   = 3000;
  localparam int CYCLE_LIMIT  = 300000;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_kind       = 1'b0;
  logic [3:0] in_byte_value = 4'd0;
  logic       out_stall     = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [3:0] out_coil_one;
  logic [3:0] out_coil_two;
  logic [3:0] out_coil_three;
  logic       out_done_pulse;
  logic       out_armed;

  int n_fail;
  int n_pending;
  int n_done;
  int n_sent   = 0;
  int n_bytes  = 0;
  int cycle_cnt = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  three_stepper_goal_sequencer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_byte_value  (in_byte_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coil_one   (out_coil_one),
    .out_coil_two   (out_coil_two),
    .out_coil_three (out_coil_three),
    .out_done_pulse (out_done_pulse),
    .out_armed      (out_armed)
  );

  three_stepper_goal_sequencer_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_byte_value  (in_byte_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coil_one   (out_coil_one),
    .out_coil_two   (out_coil_two),
    .out_coil_three (out_coil_three),
    .out_done_pulse (out_done_pulse),
    .out_armed      (out_armed),
    .n_fail         (n_fail),
    .n_pending      (n_pending),
    .n_done         (n_done)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: after each result taken, hold stall for a drawn number of cycles
  always @(posedge clk) begin : result_sink
    int n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      n = quiet ? 0 : $urandom_range(0, 4);
      stall_left <= n;
      out_stall  <= (n != 0);
    end
  end

  task automatic send_request(input logic kind, input logic [3:0] value);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_byte_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (kind == KIND_BYTE) n_bytes++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // lean towards large bytes so that goals are short and runs finish often
  function automatic logic [3:0] goal_byte();
    logic [3:0] v;
    if ($urandom_range(0, 9) < 7) v = 4'($urandom_range(13, 15));
    else v = 4'($urandom_range(0, 15));
    return v;
  endfunction

  initial begin : stimulus
    int  n_rand;
    int  r;
    int  last_done;
    int  next_mode_at;
    bit  need_goals;
    bit  paused;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ticks while disarmed, ignored byte field at both extremes
    send_request(KIND_TICK, 4'd0);
    send_request(KIND_TICK, 4'd15);
    // goals from extreme bytes, clamped ones included; third byte arms
    send_request(KIND_BYTE, 4'd0);
    send_request(KIND_BYTE, 4'd15);
    send_request(KIND_BYTE, 4'd14);
    // walk the coil phases all the way round
    repeat (5) send_request(KIND_TICK, 4'($urandom_range(0, 15)));
    // new goals while armed: block stays armed, counts kept
    repeat (3) send_request(KIND_BYTE, BYTE_MAX);
    repeat (2) send_request(KIND_TICK, 4'd0);
    send_request(KIND_BYTE, 4'd1);
    send_request(KIND_BYTE, 4'd2);
    send_request(KIND_BYTE, 4'd8);
    repeat (3) send_request(KIND_TICK, 4'd5);
    // stray byte leaves the slot out of step
    send_request(KIND_BYTE, 4'd6);
    send_request(KIND_TICK, 4'd10);
    hold_until_drained();

    n_rand       = 0;
    next_mode_at = 0;
    last_done    = n_done;
    need_goals   = 1'b1;
    paused       = 1'b0;
    while (((n_rand < RANDOM_ITEMS) || (n_done < 2)) && (n_rand < RANDOM_CAP)) begin
      if (n_rand >= next_mode_at) begin
        quiet        = ($urandom_range(0, 3) == 0);
        next_mode_at = next_mode_at + 200;
      end
      if (!paused && n_rand >= 700) begin
        hold_until_drained();
        paused = 1'b1;
      end
      if (n_done != last_done) begin
        last_done  = n_done;
        need_goals = 1'b1;
      end
      if (need_goals) begin
        repeat (3) send_request(KIND_BYTE, goal_byte());
        n_rand     = n_rand + 3;
        need_goals = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          send_request(KIND_BYTE, goal_byte());
          n_rand++;
        end else if (r == 2) begin
          need_goals = 1'b1;
        end else begin
          send_request(KIND_TICK, 4'($urandom_range(0, 15)));
          n_rand++;
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (4) @(posedge clk);
    $display("Sent %0d requests, %0d of them goal bytes; %0d runs reached their goals.",
             n_sent, n_bytes, n_done);
    $display("Result mismatches counted: %0d.", n_fail);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
